[hdl/hnf_pkg.sv]
// ---------------------------------------------------------------------------
// hnf_pkg: shared definitions for the number formatter
// Mode codes, unit bases, character codes, the interface structs between the
// control and the decimal converter, and small constant-table functions.
// ---------------------------------------------------------------------------
package hnf_pkg;

  // Mode codes; any other code prints plain decimal.
  localparam logic [1:0] MODE_SI  = 2'd1;
  localparam logic [1:0] MODE_IEC = 2'd2;

  // A remainder of a unit step is below 1024.
  localparam int REM_W  = 10;
  // A displayed human-mode integer is at most 1024.
  localparam int IVAL_W = 11;
  // Partial products of one radix-16 divider step.
  localparam int PROD_W = REM_W + 4;
  // Decimal digits of a human-mode integer.
  localparam int HUM_DIGITS = 4;

  localparam logic [IVAL_W-1:0] BASE_SI  = 11'd1000;
  localparam logic [IVAL_W-1:0] BASE_IEC = 11'd1024;
  localparam logic [2:0]        MAX_UNIT = 3'd6;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  typedef struct packed {
    logic start;
    logic short_num;
  } bcd_cmd_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [3:0] digit;
  } bcd_dig_t;

  // k times the unit base.
  function automatic logic [PROD_W-1:0] base_mult(input logic iec, input logic [3:0] k);
    logic [PROD_W-1:0] kw;
    kw = PROD_W'(k);
    base_mult = kw * PROD_W'(iec ? BASE_IEC : BASE_SI);
  endfunction

  function automatic logic [7:0] unit_char(input logic iec, input logic [2:0] u);
    logic [7:0] c;
    case (u)
      3'd1:    c = iec ? 8'h4B : 8'h6B;   // K or k
      3'd2:    c = 8'h4D;                 // M
      3'd3:    c = 8'h47;                 // G
      3'd4:    c = 8'h54;                 // T
      3'd5:    c = 8'h50;                 // P
      3'd6:    c = 8'h45;                 // E
      default: c = 8'h00;
    endcase
    unit_char = c;
  endfunction

endpackage

[hdl/hnf_div.sv]
// ---------------------------------------------------------------------------
// hnf_div: radix-16 serial divider by the unit base
// Divides the word by 1000 or 1024, one hexadecimal quotient digit per cycle,
// and returns quotient and remainder with a one-cycle done pulse.
// ---------------------------------------------------------------------------
module hnf_div #(
  parameter int VALUE_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        is_iec,
  input  logic [VALUE_BITS-1:0]       dividend,
  output logic                        done,
  output logic [VALUE_BITS-1:0]       quotient,
  output logic [hnf_pkg::REM_W-1:0]   remainder
);
  import hnf_pkg::*;

  localparam int NIB = (VALUE_BITS + 3) / 4;
  localparam int DW  = NIB * 4;
  localparam int NCW = $clog2(NIB + 1);

  logic [DW-1:0]     dd_r, dd_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [NCW-1:0]    cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              iec_r, iec_nxt;
  logic [PROD_W-1:0] part;
  logic [PROD_W-1:0] diff;
  logic [3:0]        qd;

  // One quotient digit: the partial remainder shifted by a nibble is compared
  // against all fifteen multiples of the base.
  always_comb begin
    part = {rem_r, dd_r[DW-1 -: 4]};
    qd   = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (part >= base_mult(iec_r, 4'(k))) begin
        qd = 4'(k);
      end
    end
    diff = part - base_mult(iec_r, qd);
  end

  always_comb begin
    dd_nxt   = dd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iec_nxt  = iec_r;
    if (start) begin
      dd_nxt   = DW'(dividend);
      rem_nxt  = '0;
      cnt_nxt  = NCW'(NIB);
      busy_nxt = 1'b1;
      iec_nxt  = is_iec;
    end else if (busy_r) begin
      // Quotient digits enter where dividend digits leave.
      dd_nxt  = {dd_r[DW-5:0], qd};
      rem_nxt = diff[REM_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == NCW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dd_r  <= dd_nxt;
    rem_r <= rem_nxt;
    iec_r <= iec_nxt;
  end

  assign done      = done_r;
  assign quotient  = dd_r[VALUE_BITS-1:0];
  assign remainder = rem_r;

endmodule

[hdl/hnf_bcd.sv]
// ---------------------------------------------------------------------------
// hnf_bcd: bit-serial binary to decimal converter
// Shifts the number in one bit per cycle with add-3 correction, then hands
// out the decimal digits most significant first, leading zeros dropped.
// ---------------------------------------------------------------------------
module hnf_bcd #(
  parameter int VALUE_BITS = 63
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hnf_pkg::bcd_cmd_t       cmd,
  input  logic [VALUE_BITS-1:0]   value,
  input  logic                    take,
  output hnf_pkg::bcd_dig_t       dig
);
  import hnf_pkg::*;

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int DIW    = $clog2(DIGITS);
  localparam int CW     = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_CONV = 4'b0010,
    B_SKIP = 4'b0100,
    B_OUT  = 4'b1000
  } bcd_state_t;

  bcd_state_t                 state_r, state_nxt;
  logic [VALUE_BITS-1:0]      sh_r, sh_nxt;
  logic [DIGITS-1:0][3:0]     bcd_r, bcd_nxt;
  logic [CW-1:0]              bits_r, bits_nxt;
  logic [DIW-1:0]             pos_r, pos_nxt;
  logic [DIGITS-1:0][3:0]     adj;
  logic [DIGITS-1:0][3:0]     dabble;
  logic [3:0]                 cur;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    dabble[0] = {adj[0][2:0], sh_r[VALUE_BITS-1]};
    for (int i = 1; i < DIGITS; i++) begin
      dabble[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  assign cur = bcd_r[pos_r];

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    bcd_nxt   = bcd_r;
    bits_nxt  = bits_r;
    pos_nxt   = pos_r;
    case (state_r)
      B_IDLE: begin
        if (cmd.start) begin
          sh_nxt    = value;
          bcd_nxt   = '0;
          bits_nxt  = cmd.short_num ? CW'(IVAL_W) : CW'(VALUE_BITS);
          pos_nxt   = cmd.short_num ? DIW'(HUM_DIGITS - 1) : DIW'(DIGITS - 1);
          state_nxt = B_CONV;
        end
      end
      B_CONV: begin
        bcd_nxt  = dabble;
        sh_nxt   = sh_r << 1;
        bits_nxt = bits_r - 1'b1;
        if (bits_r == CW'(1)) begin
          state_nxt = B_SKIP;
        end
      end
      B_SKIP: begin
        // The units digit is always shown, even when it is zero.
        if (pos_r != '0 && cur == 4'd0) begin
          pos_nxt = pos_r - 1'b1;
        end else begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (take) begin
          if (pos_r == '0) begin
            state_nxt = B_IDLE;
          end else begin
            pos_nxt = pos_r - 1'b1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      bits_r  <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bits_r  <= bits_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
  end

  assign dig.valid = (state_r == B_OUT);
  assign dig.last  = (pos_r == '0);
  assign dig.digit = cur;

endmodule

[hdl/human_number_formatter_unit.sv]
// ---------------------------------------------------------------------------
// human_number_formatter_unit: integer to decimal or SI/IEC text
// Prints one integer per input word as a stream of ASCII characters, the
// last one flagged, in plain decimal or scaled to a k/K..E unit.
// ---------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   cfg     | in        | cfg_we             | cfg_wdata (format mode)
//   in      | in        | in_valid/in_stall  | in_value
//   out     | out       | out_valid/out_stall| out_char_code, out_last_char
//
// Plain mode: a bit-serial conversion, the skip of leading zero digits, then the
// characters while the output is not stalled. SI/IEC mode: each unit step runs the
// serial divider by the base; then come a format step, an IVAL_W-bit conversion,
// the zero skip and the characters. Synchronous active-low reset sets plain mode
// and empties the output register. The input is stalled from acceptance until the
// last character is loaded; a stalled output holds it.
// ---------------------------------------------------------------------------
module human_number_formatter_unit #(
  parameter int VALUE_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char_code,
  output logic                  out_last_char
);
  import hnf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_FMT    = 5'b00100,
    S_DIGITS = 5'b01000,
    S_TAIL   = 5'b10000
  } ctl_state_t;

  ctl_state_t             state_r, state_nxt;
  logic [1:0]             mode_r;
  logic                   iec_r, iec_nxt;
  logic [VALUE_BITS-1:0]  q_r, q_nxt;
  logic [3:0]             c_r, c_nxt;
  logic [2:0]             u_r, u_nxt;
  logic                   div_start_r, div_start_nxt;
  logic [2:0][7:0]        tail_r, tail_nxt;
  logic [1:0]             tailn_r, tailn_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   mode_human;
  logic [IVAL_W-1:0]      in_base;
  logic                   in_big;
  logic [IVAL_W-1:0]      base;
  logic                   quo_big;
  logic [PROD_W-1:0]      cx;
  logic [3:0]             c_step;
  logic [IVAL_W-1:0]      q_lo;
  logic                   rnz;
  logic                   big;
  logic [IVAL_W-1:0]      ival;
  logic                   roll;
  logic [IVAL_W-1:0]      small_num;
  logic [3:0]             frac;
  logic [IVAL_W-1:0]      num_fmt;
  logic [2:0][7:0]        tail_fmt;
  logic [1:0]             tailn_fmt;
  logic                   out_free;
  logic                   out_load;

  logic                   div_done;
  logic [VALUE_BITS-1:0]  div_quo;
  logic [REM_W-1:0]       div_rem;
  bcd_cmd_t               bcd_cmd;
  logic [VALUE_BITS-1:0]  bcd_value;
  logic                   bcd_take;
  bcd_dig_t               bcd_dig;

  hnf_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .is_iec    (iec_r),
    .dividend  (q_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  hnf_bcd #(.VALUE_BITS(VALUE_BITS)) u_bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (bcd_cmd),
    .value (bcd_value),
    .take  (bcd_take),
    .dig   (bcd_dig)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign mode_human = (mode_r == MODE_SI) || (mode_r == MODE_IEC);
  assign in_base    = (mode_r == MODE_IEC) ? BASE_IEC : BASE_SI;
  assign in_big     = (in_value >= VALUE_BITS'(in_base));
  assign base       = iec_r ? BASE_IEC : BASE_SI;
  assign quo_big    = (div_quo >= VALUE_BITS'(base));

  // Rounding digit carried across unit steps: c is ceil(10 * r / scale) for the
  // remainder r of the value by the current scale, updated from each step's
  // remainder and the previous rounding digit. It is nonzero exactly when some remainder was nonzero.
  always_comb begin
    cx     = (PROD_W'(div_rem) << 3) + (PROD_W'(div_rem) << 1) + PROD_W'(c_r);
    c_step = 4'd0;
    for (int k = 0; k < 10; k++) begin
      if (cx > base_mult(iec_r, 4'(k))) begin
        c_step = 4'(k + 1);
      end
    end
  end

  // Final text from quotient, rounding digit and unit.
  always_comb begin
    q_lo      = q_r[IVAL_W-1:0];
    rnz       = (c_r != 4'd0);
    big       = (q_lo >= IVAL_W'(10)) || (q_lo == IVAL_W'(9) && c_r == 4'd10);
    ival      = q_lo + IVAL_W'(rnz);
    roll      = (ival >= base) && (u_r < MAX_UNIT);
    small_num = (c_r == 4'd10) ? q_lo + 1'b1 : q_lo;
    frac      = (c_r == 4'd10) ? 4'd0 : c_r;
    tail_fmt  = '0;
    if (big && roll) begin
      num_fmt     = IVAL_W'(1);
      tail_fmt[0] = CH_DOT;
      tail_fmt[1] = CH_ZERO;
      tail_fmt[2] = unit_char(iec_r, u_r + 3'd1);
      tailn_fmt   = 2'd3;
    end else if (big) begin
      num_fmt     = ival;
      tail_fmt[0] = unit_char(iec_r, u_r);
      tailn_fmt   = 2'd1;
    end else begin
      num_fmt     = small_num;
      tail_fmt[0] = CH_DOT;
      tail_fmt[1] = CH_ZERO + {4'b0000, frac};
      tail_fmt[2] = unit_char(iec_r, u_r);
      tailn_fmt   = 2'd3;
    end
  end

  assign bcd_cmd.start     = (accept && !(mode_human && in_big)) || (state_r == S_FMT);
  assign bcd_cmd.short_num = (state_r == S_FMT);
  assign bcd_value = (state_r == S_IDLE) ? in_value
                                         : {num_fmt, {(VALUE_BITS - IVAL_W){1'b0}}};

  assign out_free = !out_valid_r || !out_stall;
  assign bcd_take = (state_r == S_DIGITS) && bcd_dig.valid && out_free;

  always_comb begin
    state_nxt     = state_r;
    iec_nxt       = iec_r;
    q_nxt         = q_r;
    c_nxt         = c_r;
    u_nxt         = u_r;
    div_start_nxt = 1'b0;
    tail_nxt      = tail_r;
    tailn_nxt     = tailn_r;
    out_load      = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          iec_nxt = (mode_r == MODE_IEC);
          if (mode_human && in_big) begin
            q_nxt         = in_value;
            c_nxt         = 4'd0;
            u_nxt         = 3'd0;
            div_start_nxt = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            tailn_nxt = 2'd0;
            state_nxt = S_DIGITS;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt = div_quo;
          c_nxt = c_step;
          u_nxt = u_r + 3'd1;
          // Continue while the next larger unit still fits the value.
          if (quo_big && (u_r + 3'd1 < MAX_UNIT)) begin
            div_start_nxt = 1'b1;
          end else begin
            state_nxt = S_FMT;
          end
        end
      end
      S_FMT: begin
        tail_nxt  = tail_fmt;
        tailn_nxt = tailn_fmt;
        state_nxt = S_DIGITS;
      end
      S_DIGITS: begin
        if (bcd_take) begin
          out_load     = 1'b1;
          out_char_nxt = CH_ZERO + {4'b0000, bcd_dig.digit};
          out_last_nxt = bcd_dig.last && (tailn_r == 2'd0);
          if (bcd_dig.last) begin
            state_nxt = (tailn_r == 2'd0) ? S_IDLE : S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_nxt = tail_r[0];
          out_last_nxt = (tailn_r == 2'd1);
          tail_nxt     = {8'h00, tail_r[2:1]};
          tailn_nxt    = tailn_r - 2'd1;
          if (tailn_r == 2'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 2'd0;
      div_start_r <= 1'b0;
      tailn_r     <= 2'd0;
      u_r         <= 3'd0;
      c_r         <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      div_start_r <= div_start_nxt;
      tailn_r     <= tailn_nxt;
      u_r         <= u_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iec_r      <= iec_nxt;
    q_r        <= q_nxt;
    tail_r     <= tail_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the unit search");

  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after a word was accepted");

  a_fmt_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FMT |-> (c_r <= 4'd10) && (u_r != 3'd0) && (u_r <= MAX_UNIT))
    else $error("rounding digit or unit out of range at format time");

  a_fmt_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FMT |-> q_r < VALUE_BITS'(base))
    else $error("scaled quotient not below the base");

  a_tail_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL |-> tailn_r != 2'd0)
    else $error("suffix phase with no characters left");
`endif

endmodule
